FILE: sv/i2cms_pkg.sv
package i2cms_pkg;

    typedef enum logic [1:0] {
        ACT_START_WRITE = 2'd0,
        ACT_START_READ  = 2'd1,
        ACT_BYTE_DONE   = 2'd2,
        ACT_CLEAR_ERR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DA_NONE       = 2'd0,
        DA_WRITE      = 2'd1,
        DA_DUMMY_READ = 2'd2,
        DA_DELIVER    = 2'd3
    } data_action_t;

    localparam int ERR_NACK_BIT = 0;
    localparam int ERR_ARB_BIT  = 1;

    localparam logic [6:0] SLAVE_ADDR_RESET = 7'd8;
    localparam int         REG_SLAVE_ADDR   = 0;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] length;
        logic        bus_busy;
        logic        ack_missing;
        logic        arb_lost;
        logic [7:0]  rx_data;
        logic [7:0]  tx_data;
    } item_t;

    typedef struct packed {
        logic        start_result;
        logic [1:0]  data_action;
        logic [7:0]  data_byte;
        logic        master_on;
        logic        repeated_start;
        logic        tx_mode;
        logic        no_ack;
        logic        channel_busy;
        logic [15:0] remaining_write;
        logic [15:0] remaining_read;
        logic [1:0]  last_error;
    } result_t;

endpackage

FILE: sv/i2c_master_transfer_sequencer_top.sv
// A transaction accepted into the input register moves to the result register, and so is
// presented on the result port, at the first edge at which the result register is free.
// Throughput: one transaction per cycle while the result side does not stall.
// The rate is set by the single registered step between the input and result registers.
// Reset (rst_n, asynchronous, active low) clears all transfer state, error flags and
// both valid flags; the slave address returns to 8.
module i2c_master_transfer_sequencer_top
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [15:0] length,
    input  logic        bus_busy,
    input  logic        ack_missing,
    input  logic        arb_lost,
    input  logic [7:0]  rx_data,
    input  logic [7:0]  tx_data,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        start_result,
    output logic [1:0]  data_action,
    output logic [7:0]  data_byte,
    output logic        master_on,
    output logic        repeated_start,
    output logic        tx_mode,
    output logic        no_ack,
    output logic        channel_busy,
    output logic [15:0] remaining_write,
    output logic [15:0] remaining_read,
    output logic [1:0]  last_error
);

    // The input register holds one transaction. The step logic reads it together with the
    // transfer state and, when the result register can take a value, commits the new state
    // and loads the result in the same edge. The input register is refilled at that edge,
    // so a new transaction enters every cycle while results are being taken.
    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    step_result;
    logic       out_ready;
    logic       advance;
    logic       accept;
    logic [6:0] slave_address;

    i2cms_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .slave_address (slave_address)
    );

    i2cms_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (in_item_reg),
        .slave_address (slave_address),
        .result        (step_result)
    );

    // The result register is free when empty or when its value is taken this cycle.
    assign out_ready  = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_ready;
    assign item_stall = in_valid_reg && !out_ready;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.action      <= action;
            in_item_reg.length      <= length;
            in_item_reg.bus_busy    <= bus_busy;
            in_item_reg.ack_missing <= ack_missing;
            in_item_reg.arb_lost    <= arb_lost;
            in_item_reg.rx_data     <= rx_data;
            in_item_reg.tx_data     <= tx_data;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign result_valid    = out_valid_reg;
    assign start_result    = out_reg.start_result;
    assign data_action     = out_reg.data_action;
    assign data_byte       = out_reg.data_byte;
    assign master_on       = out_reg.master_on;
    assign repeated_start  = out_reg.repeated_start;
    assign tx_mode         = out_reg.tx_mode;
    assign no_ack          = out_reg.no_ack;
    assign channel_busy    = out_reg.channel_busy;
    assign remaining_write = out_reg.remaining_write;
    assign remaining_read  = out_reg.remaining_read;
    assign last_error      = out_reg.last_error;

endmodule

FILE: sv/i2cms_cfg.sv
module i2cms_cfg
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [6:0]  slave_address
);

    logic [6:0] slave_address_reg;
    logic [6:0] slave_address_next;
    logic       wr_en;
    logic       sel_addr_reg;

    // The register index is the word address, paddr[2].
    assign sel_addr_reg = (paddr[2] == 1'(REG_SLAVE_ADDR));
    assign wr_en        = psel && penable && pwrite && sel_addr_reg;
    assign pready       = 1'b1;

    always_comb
    begin
        slave_address_next = slave_address_reg;
        if (wr_en)
        begin
            slave_address_next = pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDR_RESET;
        end
        else
        begin
            slave_address_reg <= slave_address_next;
        end
    end

    assign prdata        = sel_addr_reg ? {25'd0, slave_address_reg} : 32'd0;
    assign slave_address = slave_address_reg;

endmodule

FILE: sv/i2cms_step.sv
module i2cms_step
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  item_t      item,
    input  logic [6:0] slave_address,
    output result_t    result
);

    logic [15:0] write_left_reg, write_left_next;
    logic [15:0] read_left_reg,  read_left_next;
    logic        busy_reg,       busy_next;
    logic        master_reg,     master_next;
    logic        tx_mode_reg,    tx_mode_next;
    logic        nack_reg,       nack_next;
    logic [1:0]  err_reg,        err_next;

    logic        start_result;
    logic [1:0]  data_action;
    logic [7:0]  data_byte;
    logic        rstart;
    logic [15:0] rd_dec;

    always_comb
    begin
        write_left_next = write_left_reg;
        read_left_next  = read_left_reg;
        busy_next       = busy_reg;
        master_next     = master_reg;
        tx_mode_next    = tx_mode_reg;
        nack_next       = nack_reg;
        err_next        = err_reg;
        start_result    = 1'b0;
        data_action     = DA_NONE;
        data_byte       = 8'd0;
        rstart          = 1'b0;
        rd_dec          = (read_left_reg != 16'd0) ? (read_left_reg - 16'd1) : 16'd0;

        unique case (action_t'(item.action))
            ACT_START_WRITE, ACT_START_READ:
            begin
                if (item.length != 16'd0)
                begin
                    if (item.bus_busy || busy_reg || (read_left_reg != 16'd0))
                    begin
                        start_result = 1'b1;
                    end
                    else
                    begin
                        tx_mode_next = 1'b1;
                        if (item.action == ACT_START_WRITE)
                        begin
                            write_left_next = item.length;
                            busy_next       = 1'b1;
                        end
                        else
                        begin
                            read_left_next = item.length;
                        end
                        rstart      = master_reg;
                        master_next = 1'b1;
                        data_action = DA_WRITE;
                        data_byte   = {slave_address, item.action[0]};
                    end
                end
            end
            ACT_BYTE_DONE:
            begin
                if (item.arb_lost)
                begin
                    write_left_next       = 16'd0;
                    read_left_next        = 16'd0;
                    tx_mode_next          = 1'b0;
                    busy_next             = 1'b0;
                    err_next[ERR_ARB_BIT] = 1'b1;
                end
                else if (tx_mode_reg)
                begin
                    if (item.ack_missing)
                    begin
                        write_left_next        = 16'd0;
                        read_left_next         = 16'd0;
                        tx_mode_next           = 1'b0;
                        busy_next              = 1'b0;
                        master_next            = 1'b0;
                        err_next[ERR_NACK_BIT] = 1'b1;
                    end
                    else if (write_left_reg != 16'd0)
                    begin
                        write_left_next = write_left_reg - 16'd1;
                        data_action     = DA_WRITE;
                        data_byte       = item.tx_data;
                    end
                    else if (read_left_reg != 16'd0)
                    begin
                        nack_next    = (read_left_reg == 16'd1);
                        tx_mode_next = 1'b0;
                        data_action  = DA_DUMMY_READ;
                    end
                    else
                    begin
                        busy_next    = 1'b0;
                        master_next  = 1'b0;
                        tx_mode_next = 1'b0;
                    end
                end
                else
                begin
                    // Receive side: an event with nothing pending holds the count at zero.
                    read_left_next = rd_dec;
                    if (rd_dec != 16'd0)
                    begin
                        if (rd_dec == 16'd1)
                        begin
                            nack_next = 1'b1;
                        end
                    end
                    else
                    begin
                        master_next = 1'b0;
                        nack_next   = 1'b0;
                    end
                    data_action = DA_DELIVER;
                    data_byte   = item.rx_data;
                end
            end
            ACT_CLEAR_ERR:
            begin
                err_next = 2'd0;
            end
            default:
            begin
                err_next = err_reg;
            end
        endcase

        result.start_result    = start_result;
        result.data_action     = data_action;
        result.data_byte       = data_byte;
        result.master_on       = master_next;
        result.repeated_start  = rstart;
        result.tx_mode         = tx_mode_next;
        result.no_ack          = nack_next;
        result.channel_busy    = busy_next;
        result.remaining_write = write_left_next;
        result.remaining_read  = read_left_next;
        // The clear reports the flags held before it.
        result.last_error      = (item.action == ACT_CLEAR_ERR) ? err_reg : err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_left_reg <= 16'd0;
            read_left_reg  <= 16'd0;
            busy_reg       <= 1'b0;
            master_reg     <= 1'b0;
            tx_mode_reg    <= 1'b0;
            nack_reg       <= 1'b0;
            err_reg        <= 2'd0;
        end
        else if (advance)
        begin
            write_left_reg <= write_left_next;
            read_left_reg  <= read_left_next;
            busy_reg       <= busy_next;
            master_reg     <= master_next;
            tx_mode_reg    <= tx_mode_next;
            nack_reg       <= nack_next;
            err_reg        <= err_next;
        end
    end

endmodule

FILE: sv/i2cms_checker.sv
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic        start_result,
    input logic [1:0]  data_action,
    input logic [7:0]  data_byte,
    input logic        master_on,
    input logic        repeated_start,
    input logic        tx_mode,
    input logic        channel_busy,
    input logic [15:0] remaining_read
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A repeated start only comes with an accepted start that writes the address byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && repeated_start |->
            master_on && !start_result && data_action == DA_WRITE && tx_mode)
        else $error("repeated start without an accepted start");

    // A refused start performs no data action.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && start_result |-> data_action == DA_NONE)
        else $error("refused start moved data");

    // The dummy read switches to receive and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && data_action == DA_DUMMY_READ |-> !tx_mode && data_byte == 8'd0)
        else $error("dummy read in transmit mode or with data");

    // A write transfer never runs while a read is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && channel_busy |-> remaining_read == 16'd0)
        else $error("write and read pending together");

endmodule

bind i2c_master_transfer_sequencer_top i2cms_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .start_result   (start_result),
    .data_action    (data_action),
    .data_byte      (data_byte),
    .master_on      (master_on),
    .repeated_start (repeated_start),
    .tx_mode        (tx_mode),
    .channel_busy   (channel_busy),
    .remaining_read (remaining_read)
);
